/* hdl/vsbc_pkg.sv */
// Shared constants, types and helpers for the swept-box voxel collision block.
package vsbc_pkg;

	// World and sub-step sizing.
	localparam int WORLD_CELLS  = 64;
	localparam int MAX_SUBSTEPS = 16;
	localparam int CW           = $clog2(WORLD_CELLS);
	localparam int ROW_AW       = 2 * CW;
	localparam int ROWS         = WORLD_CELLS * WORLD_CELLS;
	localparam int CELL_COUNT   = WORLD_CELLS * WORLD_CELLS * WORLD_CELLS;
	localparam int STEP_W       = $clog2(MAX_SUBSTEPS + 1);
	localparam int FT_W         = 16;

	// Bound arithmetic is carried at this width, Q.16 signed.
	localparam int LW = 36;
	localparam logic signed [LW-1:0] ONE_L   = LW'(65536);
	localparam logic signed [LW-1:0] FRAC_L  = LW'(65535);
	localparam logic signed [LW-1:0] WQ_L    = LW'(WORLD_CELLS * 65536);
	localparam logic signed [LW-1:0] WMAX_L  = LW'(WORLD_CELLS - 1);

	// Register reset values.
	localparam logic [15:0]        FRAME_TIME_RST = 16'd1092;
	localparam logic signed [31:0] GRAVITY_RST    = -32'sd642253;
	localparam logic [15:0]        FALL_GAIN_RST  = 16'd256;
	localparam logic [15:0]        RISE_GAIN_RST  = 16'd256;
	localparam logic [30:0]        SPEED_LIM_RST  = 31'd3276800;
	localparam logic               COLLIDE_RST    = 1'b1;

	typedef enum logic [1:0] {
		MODE_WRITE  = 2'd0,
		MODE_GROUND = 2'd1,
		MODE_DEBUG  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		CFG_FRAME_TIME = 3'd0,
		CFG_GRAVITY    = 3'd1,
		CFG_FALL_GAIN  = 3'd2,
		CFG_RISE_GAIN  = 3'd3,
		CFG_SPEED_LIM  = 3'd4,
		CFG_COLLIDE    = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MUL_DT_GAIN = 2'd0,
		MUL_GRAV    = 2'd1,
		MUL_DT_VEL  = 2'd2,
		MUL_SDT_VEL = 2'd3
	} mul_sel_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_RD,
		ST_WR_WR,
		ST_G_GAIN,
		ST_G_MUL,
		ST_G_APPLY,
		ST_SPLIT,
		ST_MX_MUL,
		ST_MX_ACC,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_AX_CHECK,
		ST_D_MUL,
		ST_D_ACC,
		ST_BOUNDS,
		ST_RANGE,
		ST_SCAN_CHK,
		ST_ROW_RD,
		ST_X_SCAN,
		ST_RESOLVE,
		ST_NEXT,
		ST_FREE,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       mul_en;
		mul_sel_t   mul_sel;
		logic [1:0] k;
		logic [1:0] ax;
		logic       grav_apply;
		logic       mx_acc;
		logic       div_start;
		logic       sdt_div;
		logic       sdt_dt;
		logic       d_acc;
		logic       bounds;
		logic       range;
		logic       row_rd;
		logic       x_step;
		logic       next_y;
		logic       next_z;
		logic       resolve;
		logic       free_apply;
		logic       wr_rd;
		logic       wr_wr;
		logic       clr;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic              collide_on;
		logic              clr_last;
		logic              div_done;
		logic              vel_zero;
		logic              range_empty;
		logic              x_last;
		logic              y_last;
		logic              z_last;
		logic [STEP_W-1:0] steps;
	} sts_t;

	// Saturate a sum to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -34'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

/* hdl/voxel_swept_box_collision.sv */
// Top level of the swept-box voxel collision block.
//
// Keeps a 64x64x64 one-bit solid map and moves a box through it. After reset the
// map is cleared one x row per cycle with busy high; configuration writes are
// taken throughout. A cell write reads the row, modifies it and writes it back,
// and gives no result. An update first sets up (gravity on the shared multiplier
// in ground mode, three displacement magnitudes and a divide of the frame time by
// the sub-step count), then for every sub-step and every moving axis computes the
// displacement and bounds and, per (y,z) row of the swept range, does one row read
// and scans the x cells of that row one per cycle: the cell scan dominates the
// time. An axis at rest is skipped for that sub-step. Without collision an update
// skips the sub-steps and the scan. Each result is shown for one cycle with done
// high and cannot be held off; the next item is taken once busy falls.
module voxel_swept_box_collision (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic [1:0]         mode,
	input  logic [17:0]        cell_index,
	input  logic               cell_solid,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] vel_z,
	input  logic [18:0]        half_x,
	input  logic [18:0]        half_y,
	input  logic [18:0]        half_z,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic signed [31:0] new_pos_x,
	output logic signed [31:0] new_pos_y,
	output logic signed [31:0] new_pos_z,
	output logic signed [31:0] new_vel_x,
	output logic signed [31:0] new_vel_y,
	output logic signed [31:0] new_vel_z,
	output logic               grounded
);
	import vsbc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	vsbc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	vsbc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cell_index (cell_index),
		.cell_solid (cell_solid),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.vel_x      (vel_x),
		.vel_y      (vel_y),
		.vel_z      (vel_z),
		.half_x     (half_x),
		.half_y     (half_y),
		.half_z     (half_z),
		.new_pos_x  (new_pos_x),
		.new_pos_y  (new_pos_y),
		.new_pos_z  (new_pos_z),
		.new_vel_x  (new_vel_x),
		.new_vel_y  (new_vel_y),
		.new_vel_z  (new_vel_z),
		.grounded   (grounded)
	);

	// A result word is a single-cycle strobe.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// A grounded box has its vertical velocity stopped.
	a_ground_stop: assert property (@(posedge clk) disable iff (!arst_n)
		done && grounded |-> new_vel_z == 0)
		else $error("grounded result with nonzero vertical velocity");

	// A cell write never produces a result word.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && mode == MODE_WRITE |=> !done ##1 !done)
		else $error("result word after a cell write");

endmodule

/* hdl/vsbc_ram.sv */
// Generic single-port RAM with registered read data.
module vsbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Up to one write and one read per cycle, both at the shared address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[addr];
		end
	end

	assign rdata = rd_data_q;

endmodule

/* hdl/vsbc_div.sv */
// Restoring divider that splits the frame time by the sub-step count.
module vsbc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [vsbc_pkg::FT_W-1:0]  dividend,
	input  logic [vsbc_pkg::STEP_W-1:0] divisor,
	output logic                       done,
	output logic [vsbc_pkg::FT_W-1:0]  quotient
);
	import vsbc_pkg::*;

	localparam int CNT_W = $clog2(FT_W + 1);

	logic              run_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [STEP_W-1:0] rem_q;
	logic [STEP_W-1:0] den_q;
	logic [FT_W-1:0]   quo_q;
	logic [STEP_W:0]   trial;
	logic              fits;

	// One quotient bit per cycle.
	assign trial = {rem_q, quo_q[FT_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= CNT_W'(FT_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (run_q) begin
			if (fits) begin
				rem_q <= STEP_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[STEP_W-1:0];
			end
			quo_q <= {quo_q[FT_W-2:0], fits};
		end
	end

	assign done     = !run_q;
	assign quotient = quo_q;

endmodule

/* hdl/vsbc_dp.sv */
// Datapath: registers, shared multiplier, bound logic, cell scan and solid map.
module vsbc_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  vsbc_pkg::cmd_t      cmd,
	output vsbc_pkg::sts_t      sts,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic [17:0]         cell_index,
	input  logic                cell_solid,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	input  logic signed [31:0]  vel_x,
	input  logic signed [31:0]  vel_y,
	input  logic signed [31:0]  vel_z,
	input  logic [18:0]         half_x,
	input  logic [18:0]         half_y,
	input  logic [18:0]         half_z,
	output logic signed [31:0]  new_pos_x,
	output logic signed [31:0]  new_pos_y,
	output logic signed [31:0]  new_pos_z,
	output logic signed [31:0]  new_vel_x,
	output logic signed [31:0]  new_vel_y,
	output logic signed [31:0]  new_vel_z,
	output logic                grounded
);
	import vsbc_pkg::*;

	// Configuration registers.
	logic [15:0]        frame_time_q;
	logic signed [31:0] gravity_q;
	logic [15:0]        fall_gain_q;
	logic [15:0]        rise_gain_q;
	logic [30:0]        speed_lim_q;
	logic               collide_q;

	// Item registers.
	logic [17:0]        idx_q;
	logic               solid_q;
	logic signed [31:0] pos_q [0:2];
	logic signed [31:0] vel_q [0:2];
	logic [18:0]        half_q [0:2];
	logic               ground_q;

	// Arithmetic registers.
	logic signed [64:0] prod_q;
	logic [47:0]        mx_q;
	logic [STEP_W-1:0]  steps_q;
	logic [15:0]        sdt_q;
	logic signed [32:0] d_q [0:2];

	// Bound and scan registers.
	logic signed [LW-1:0] lo_q [0:2];
	logic signed [LW-1:0] hi_q [0:2];
	logic signed [LW-1:0] ld_q;
	logic signed [LW-1:0] hd_q;
	logic [CW-1:0]        glo_q [0:2];
	logic [CW-1:0]        ghi_q [0:2];
	logic                 empty_q;
	logic [CW-1:0]        cx_q;
	logic [CW-1:0]        cy_q;
	logic [CW-1:0]        cz_q;
	logic                 found_q;
	logic signed [LW-1:0] best_q;
	logic [ROW_AW-1:0]    clr_addr_q;

	// Configuration writes; the port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_time_q <= FRAME_TIME_RST;
			gravity_q    <= GRAVITY_RST;
			fall_gain_q  <= FALL_GAIN_RST;
			rise_gain_q  <= RISE_GAIN_RST;
			speed_lim_q  <= SPEED_LIM_RST;
			collide_q    <= COLLIDE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FRAME_TIME: frame_time_q <= cfg_data[15:0];
				CFG_GRAVITY:    gravity_q    <= $signed(cfg_data);
				CFG_FALL_GAIN:  fall_gain_q  <= cfg_data[15:0];
				CFG_RISE_GAIN:  rise_gain_q  <= cfg_data[15:0];
				CFG_SPEED_LIM:  speed_lim_q  <= cfg_data[30:0];
				CFG_COLLIDE:    collide_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Shared multiplier operand selection.
	logic signed [32:0] mul_a;
	logic signed [31:0] mul_b;
	logic [15:0]        gain;

	assign gain = (vel_q[2] <= 0) ? fall_gain_q : rise_gain_q;

	always_comb begin
		case (cmd.mul_sel)
			MUL_DT_GAIN: begin
				mul_a = $signed({17'd0, frame_time_q});
				mul_b = $signed({16'd0, gain});
			end
			MUL_GRAV: begin
				mul_a = $signed({1'b0, prod_q[31:0]});
				mul_b = gravity_q;
			end
			MUL_DT_VEL: begin
				mul_a = $signed({17'd0, frame_time_q});
				mul_b = vel_q[cmd.k];
			end
			default: begin
				mul_a = $signed({17'd0, sdt_q});
				mul_b = vel_q[cmd.k];
			end
		endcase
	end

	// Gravity update and clamp of the vertical velocity.
	logic signed [40:0] dz;
	logic signed [41:0] vsum;
	logic signed [41:0] lim_p;
	logic signed [41:0] lim_n;
	logic signed [31:0] vclamp;

	assign dz    = prod_q[64:24];
	assign vsum  = 42'(vel_q[2]) + 42'(dz);
	assign lim_p = $signed({11'd0, speed_lim_q});
	assign lim_n = -lim_p;

	always_comb begin
		if (vsum > lim_p) begin
			vclamp = lim_p[31:0];
		end else if (vsum < lim_n) begin
			vclamp = lim_n[31:0];
		end else begin
			vclamp = vsum[31:0];
		end
	end

	// Magnitude of a frame displacement and the sub-step count.
	logic signed [48:0] m49;
	logic [47:0]        mabs;
	logic [48:0]        msum;
	logic [16:0]        st_raw;
	logic [STEP_W-1:0]  steps_c;

	assign m49    = prod_q[48:0];
	assign mabs   = m49[48] ? 48'(-m49) : m49[47:0];
	assign msum   = {1'b0, mx_q} + 49'h0_FFFF_FFFF;
	assign st_raw = msum[48:32];

	always_comb begin
		if (st_raw == 17'd0) begin
			steps_c = STEP_W'(1);
		end else if (st_raw > 17'(MAX_SUBSTEPS)) begin
			steps_c = STEP_W'(MAX_SUBSTEPS);
		end else begin
			steps_c = st_raw[STEP_W-1:0];
		end
	end

	logic        div_done;
	logic [15:0] div_q;

	vsbc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (frame_time_q),
		.divisor  (steps_c),
		.done     (div_done),
		.quotient (div_q)
	);

	// Box bounds per axis, clipped to the world.
	logic signed [LW-1:0] lo_raw [0:2];
	logic signed [LW-1:0] hi_raw [0:2];
	logic signed [LW-1:0] half_l [0:2];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			half_l[k] = $signed({{(LW-19){1'b0}}, half_q[k]});
			lo_raw[k] = LW'(pos_q[k]) - half_l[k];
			hi_raw[k] = LW'(pos_q[k]) + half_l[k];
		end
	end

	// Swept cell range per axis.
	logic signed [LW-1:0] dk [0:2];
	logic signed [LW-1:0] smin [0:2];
	logic signed [LW-1:0] smax [0:2];
	logic signed [LW-1:0] glo_f [0:2];
	logic signed [LW-1:0] ghi_f [0:2];
	logic signed [LW-1:0] glo_c [0:2];
	logic signed [LW-1:0] ghi_c [0:2];
	logic [2:0]           emp;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dk[k]    = LW'(d_q[k]);
			smin[k]  = (dk[k] < 0) ? lo_q[k] + dk[k] : lo_q[k];
			smax[k]  = (dk[k] > 0) ? hi_q[k] + dk[k] : hi_q[k];
			glo_f[k] = smin[k] >>> 16;
			ghi_f[k] = ((smax[k] + FRAC_L) >>> 16) - LW'(1);
			glo_c[k] = (glo_f[k] < 0) ? '0 : glo_f[k];
			ghi_c[k] = (ghi_f[k] > WMAX_L) ? WMAX_L : ghi_f[k];
			emp[k]   = glo_c[k] > ghi_c[k];
		end
	end

	// Solid map, one x row per word.
	logic [WORLD_CELLS-1:0] row_data;
	logic [WORLD_CELLS-1:0] row_wdata;
	logic [ROW_AW-1:0]      ram_addr;
	logic                   ram_we;
	logic                   ram_re;
	logic [31:0]            idx_ext;
	logic                   idx_ok;

	assign idx_ext = 32'(idx_q);
	assign idx_ok  = idx_ext < 32'(CELL_COUNT);

	always_comb begin
		row_wdata = row_data;
		row_wdata[idx_ext[CW-1:0]] = solid_q;
	end

	always_comb begin
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		ram_addr = {cz_q, cy_q};
		if (cmd.clr) begin
			ram_we   = 1'b1;
			ram_addr = clr_addr_q;
		end else if (cmd.wr_rd) begin
			ram_re   = 1'b1;
			ram_addr = idx_ext[3*CW-1:CW];
		end else if (cmd.wr_wr) begin
			ram_we   = idx_ok;
			ram_addr = idx_ext[3*CW-1:CW];
		end else if (cmd.row_rd) begin
			ram_re   = 1'b1;
		end
	end

	vsbc_ram #(
		.WIDTH (WORLD_CELLS),
		.DEPTH (ROWS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (cmd.clr ? '0 : row_wdata),
		.rdata (row_data)
	);

	// Clearing sweep address after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Test of the current cell against the moving axis.
	logic [CW-1:0]        c_w [0:2];
	logic signed [LW-1:0] cell_lo [0:2];
	logic                 skip;
	logic                 vel_pos;
	logic signed [LW-1:0] f_up;
	logic signed [LW-1:0] f_dn;
	logic                 cand;
	logic                 hit;

	assign c_w[0]  = cx_q;
	assign c_w[1]  = cy_q;
	assign c_w[2]  = cz_q;
	assign vel_pos = vel_q[cmd.ax] > 0;

	always_comb begin
		skip = 1'b0;
		for (int k = 0; k < 3; k++) begin
			cell_lo[k] = $signed({{(LW-CW-16){1'b0}}, c_w[k], 16'd0});
			if (2'(k) != cmd.ax &&
			    (hi_q[k] <= cell_lo[k] || lo_q[k] >= cell_lo[k] + ONE_L)) begin
				skip = 1'b1;
			end
		end
		f_up = cell_lo[cmd.ax];
		f_dn = cell_lo[cmd.ax] + ONE_L;
		if (vel_pos) begin
			cand = f_up >= hi_q[cmd.ax] && f_up <= hd_q && (!found_q || f_up < best_q);
		end else begin
			cand = f_dn <= lo_q[cmd.ax] && f_dn >= ld_q && (!found_q || f_dn > best_q);
		end
		hit = !skip && row_data[cx_q] && cand;
	end

	// Resolved position of the moving axis.
	logic signed [LW-1:0] stop_pos;
	logic signed [31:0]   free_pos [0:2];

	assign stop_pos = vel_pos ? best_q - half_l[cmd.ax] : best_q + half_l[cmd.ax];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			free_pos[k] = sat32(34'(pos_q[k]) + 34'(d_q[k]));
		end
	end

	// Item and working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q     <= cell_index;
			solid_q   <= cell_solid;
			pos_q[0]  <= pos_x;
			pos_q[1]  <= pos_y;
			pos_q[2]  <= pos_z;
			vel_q[0]  <= vel_x;
			vel_q[1]  <= vel_y;
			vel_q[2]  <= vel_z;
			half_q[0] <= half_x;
			half_q[1] <= half_y;
			half_q[2] <= half_z;
			ground_q  <= 1'b0;
			mx_q      <= '0;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.grav_apply) begin
			vel_q[2] <= vclamp;
		end
		if (cmd.mx_acc && mabs > mx_q) begin
			mx_q <= mabs;
		end
		if (cmd.div_start) begin
			steps_q <= steps_c;
		end
		if (cmd.sdt_div) begin
			sdt_q <= div_q;
		end
		if (cmd.sdt_dt) begin
			sdt_q <= frame_time_q;
		end
		if (cmd.d_acc) begin
			d_q[cmd.k] <= prod_q[48:16];
		end
		if (cmd.bounds) begin
			for (int k = 0; k < 3; k++) begin
				lo_q[k] <= (lo_raw[k] < 0) ? '0 : lo_raw[k];
				hi_q[k] <= (hi_raw[k] > WQ_L) ? WQ_L : hi_raw[k];
			end
		end
		if (cmd.range) begin
			for (int k = 0; k < 3; k++) begin
				glo_q[k] <= glo_c[k][CW-1:0];
				ghi_q[k] <= ghi_c[k][CW-1:0];
			end
			empty_q <= |emp;
			ld_q    <= lo_q[cmd.ax] + dk[cmd.ax];
			hd_q    <= hi_q[cmd.ax] + dk[cmd.ax];
			cy_q    <= glo_c[1][CW-1:0];
			cz_q    <= glo_c[2][CW-1:0];
			found_q <= 1'b0;
		end
		if (cmd.row_rd) begin
			cx_q <= glo_q[0];
		end
		if (cmd.x_step) begin
			cx_q <= cx_q + 1'b1;
			if (hit) begin
				found_q <= 1'b1;
				best_q  <= vel_pos ? f_up : f_dn;
			end
		end
		if (cmd.next_y) begin
			cy_q <= cy_q + 1'b1;
		end
		if (cmd.next_z) begin
			cz_q <= cz_q + 1'b1;
			cy_q <= glo_q[1];
		end
		if (cmd.resolve) begin
			if (found_q) begin
				pos_q[cmd.ax] <= stop_pos[31:0];
				vel_q[cmd.ax] <= '0;
				if (cmd.ax == 2'd2 && !vel_pos) begin
					ground_q <= 1'b1;
				end
			end else begin
				pos_q[cmd.ax] <= free_pos[cmd.ax];
			end
		end
		if (cmd.free_apply) begin
			for (int k = 0; k < 3; k++) begin
				pos_q[k] <= free_pos[k];
			end
		end
	end

	// Status back to the controller.
	assign sts.collide_on  = collide_q;
	assign sts.clr_last    = clr_addr_q == ROW_AW'(ROWS - 1);
	assign sts.div_done    = div_done;
	assign sts.vel_zero    = vel_q[cmd.ax] == 0;
	assign sts.range_empty = empty_q;
	assign sts.x_last      = cx_q == ghi_q[0];
	assign sts.y_last      = cy_q == ghi_q[1];
	assign sts.z_last      = cz_q == ghi_q[2];
	assign sts.steps       = steps_q;

	assign new_pos_x = pos_q[0];
	assign new_pos_y = pos_q[1];
	assign new_pos_z = pos_q[2];
	assign new_vel_x = vel_q[0];
	assign new_vel_y = vel_q[1];
	assign new_vel_z = vel_q[2];
	assign grounded  = ground_q;

endmodule

/* hdl/vsbc_ctrl.sv */
// Controller state machine that sequences cell writes, gravity, sub-steps and the cell scan.
module vsbc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     mode,
	output logic           busy,
	output logic           done,
	output vsbc_pkg::cmd_t cmd,
	input  vsbc_pkg::sts_t sts
);
	import vsbc_pkg::*;

	state_t            state_q, state_d;
	logic [1:0]        k_q, k_d;
	logic [1:0]        a_q, a_d;
	logic [STEP_W-1:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			k_q     <= '0;
			a_q     <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			a_q     <= a_d;
			step_q  <= step_d;
		end
	end

	// Next state and loop counters.
	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		a_d     = a_q;
		step_d  = step_q;
		unique case (state_q)
			ST_CLEAR: if (sts.clr_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (start) begin
					unique case (mode_t'(mode))
						MODE_WRITE:  state_d = ST_WR_RD;
						MODE_GROUND: state_d = ST_G_GAIN;
						MODE_DEBUG:  state_d = ST_SPLIT;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_WR_RD:   state_d = ST_WR_WR;
			ST_WR_WR:   state_d = ST_IDLE;
			ST_G_GAIN:  state_d = ST_G_MUL;
			ST_G_MUL:   state_d = ST_G_APPLY;
			ST_G_APPLY: state_d = ST_SPLIT;
			ST_SPLIT: begin
				k_d     = '0;
				state_d = sts.collide_on ? ST_MX_MUL : ST_D_MUL;
			end
			ST_MX_MUL: state_d = ST_MX_ACC;
			ST_MX_ACC: begin
				if (k_q == 2'd2) begin
					state_d = ST_DIV_GO;
				end else begin
					k_d     = k_q + 1'b1;
					state_d = ST_MX_MUL;
				end
			end
			ST_DIV_GO: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					step_d  = '0;
					a_d     = '0;
					state_d = ST_AX_CHECK;
				end
			end
			ST_AX_CHECK: begin
				if (sts.vel_zero) begin
					state_d = ST_NEXT;
				end else begin
					k_d     = '0;
					state_d = ST_D_MUL;
				end
			end
			ST_D_MUL: state_d = ST_D_ACC;
			ST_D_ACC: begin
				if (k_q == 2'd2) begin
					state_d = sts.collide_on ? ST_BOUNDS : ST_FREE;
				end else begin
					k_d     = k_q + 1'b1;
					state_d = ST_D_MUL;
				end
			end
			ST_BOUNDS:   state_d = ST_RANGE;
			ST_RANGE:    state_d = ST_SCAN_CHK;
			ST_SCAN_CHK: state_d = sts.range_empty ? ST_RESOLVE : ST_ROW_RD;
			ST_ROW_RD:   state_d = ST_X_SCAN;
			ST_X_SCAN: begin
				if (sts.x_last) begin
					if (sts.y_last && sts.z_last) begin
						state_d = ST_RESOLVE;
					end else begin
						state_d = ST_ROW_RD;
					end
				end
			end
			ST_RESOLVE: state_d = ST_NEXT;
			ST_NEXT: begin
				if (a_q == 2'd2) begin
					a_d = '0;
					if (STEP_W'(step_q + 1'b1) == sts.steps) begin
						state_d = ST_OUT;
					end else begin
						step_d  = step_q + 1'b1;
						state_d = ST_AX_CHECK;
					end
				end else begin
					a_d     = a_q + 1'b1;
					state_d = ST_AX_CHECK;
				end
			end
			ST_FREE: state_d = ST_OUT;
			ST_OUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands per state.
	always_comb begin
		cmd    = '0;
		cmd.k  = k_q;
		cmd.ax = a_q;
		unique case (state_q)
			ST_CLEAR: cmd.clr = 1'b1;
			ST_IDLE:  cmd.load = start;
			ST_WR_RD: cmd.wr_rd = 1'b1;
			ST_WR_WR: cmd.wr_wr = 1'b1;
			ST_G_GAIN: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_DT_GAIN;
			end
			ST_G_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_GRAV;
			end
			ST_G_APPLY: cmd.grav_apply = 1'b1;
			ST_SPLIT:   cmd.sdt_dt = !sts.collide_on;
			ST_MX_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_DT_VEL;
			end
			ST_MX_ACC:   cmd.mx_acc = 1'b1;
			ST_DIV_GO:   cmd.div_start = 1'b1;
			ST_DIV_WAIT: cmd.sdt_div = sts.div_done;
			ST_D_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SDT_VEL;
			end
			ST_D_ACC:  cmd.d_acc = 1'b1;
			ST_BOUNDS: cmd.bounds = 1'b1;
			ST_RANGE:  cmd.range = 1'b1;
			ST_ROW_RD: cmd.row_rd = 1'b1;
			ST_X_SCAN: begin
				cmd.x_step = 1'b1;
				cmd.next_y = sts.x_last && !sts.y_last;
				cmd.next_z = sts.x_last && sts.y_last && !sts.z_last;
			end
			ST_RESOLVE: cmd.resolve = 1'b1;
			ST_FREE:    cmd.free_apply = 1'b1;
			default: ;
		endcase
	end

	assign busy = state_q != ST_IDLE;
	assign done = state_q == ST_OUT;

endmodule
